// ----- sv/i4wnp_pkg.sv -----
// Package for the int4 weight nibble placer.
// Item types, status and register codes, limits and slot tables.
// No dependencies.
package i4wnp_pkg;

	// Field widths
	localparam int unsigned ChannelW = 9;
	localparam int unsigned ReduceW  = 12;
	localparam int unsigned ByteW    = 8;
	localparam int unsigned AddrW    = 19;
	localparam int unsigned NibbleW  = 4;

	// Supported geometry limits
	localparam int unsigned MaxGroups    = 32;
	localparam int unsigned MaxReduction = 2048;

	// Register reset values
	localparam logic [ReduceW-1:0]  ReductionReset = 12'd64;
	localparam logic [ChannelW-1:0] ChannelReset   = 9'd64;
	localparam logic                OrderReset     = 1'b0;

	// Result status codes
	typedef enum logic [1:0] {
		STATUS_PLACED   = 2'd0,
		STATUS_SKIPPED  = 2'd1,
		STATUS_GEOMETRY = 2'd2
	} status_t;

	// Register indexes (paddr[3:2])
	typedef enum logic [1:0] {
		REG_REDUCTION = 2'd0,
		REG_CHANNELS  = 2'd1,
		REG_ORDER     = 2'd2
	} reg_idx_t;

	// Nibble orders
	localparam logic ORDER_PAIRED = 1'b0;
	localparam logic ORDER_SPLIT  = 1'b1;

	// Input item: one weight
	typedef struct packed {
		logic [ChannelW-1:0] channel;
		logic [ReduceW-1:0]  reduce_index;
		logic [ByteW-1:0]    weight_byte;
	} weight_item_t;

	// Result item: where the nibble goes
	typedef struct packed {
		status_t             status;
		logic [AddrW-1:0]    byte_address;
		logic                high_half;
		logic [NibbleW-1:0]  nibble;
	} place_item_t;

	// Slot of the three-slot block when the group count is 3 mod 4
	function automatic logic [1:0] slot_mod3(input logic [1:0] idx);
		logic [1:0] s;
		case (idx)
			2'd0:    s = 2'd0;
			2'd1:    s = 2'd2;
			2'd2:    s = 2'd3;
			default: s = 2'd0;
		endcase
		return s;
	endfunction

	// Slot of the three-slot block when the group count is 1 mod 4
	function automatic logic [1:0] slot_mod1(input logic [1:0] idx);
		logic [1:0] s;
		case (idx)
			2'd0:    s = 2'd0;
			2'd1:    s = 2'd1;
			2'd2:    s = 2'd3;
			default: s = 2'd0;
		endcase
		return s;
	endfunction

endpackage

// ----- sv/int4_weight_nibble_placer.sv -----
// Top level of the int4 weight nibble placer: config registers, input
// register, placement logic and result register. Depends on i4wnp_pkg.
//
// Channel   | Signals                                  | Direction
// ----------+------------------------------------------+----------
// weight in | start, busy, weight (weight_item_t)      | in/out
// result    | done, place (place_item_t)               | out
// config    | psel, penable, pwrite, paddr, pwdata,    | in/out
//           | prdata, pready                           |
//
// One item per cycle; each result is registered in the input register and then in the
// result register, around the single placement stage.
// busy is always low. done is a one-cycle strobe; the receiver cannot stall.
// Reset clears the pipeline valids and loads K=64, N=64, nibble order 0.
module int4_weight_nibble_placer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  i4wnp_pkg::weight_item_t   weight,
	output logic                      done,
	output i4wnp_pkg::place_item_t    place,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [3:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import i4wnp_pkg::*;

	logic [ReduceW-1:0]  reduction_length_q;
	logic [ChannelW-1:0] channel_count_q;
	logic                nibble_order_q;

	logic         valid_s1;
	weight_item_t item_s1;
	logic         valid_s2;
	place_item_t  place_s2;

	reg_idx_t  reg_idx;
	logic      cfg_wr;

	// Config port
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reduction_length_q <= ReductionReset;
			channel_count_q    <= ChannelReset;
			nibble_order_q     <= OrderReset;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_REDUCTION: reduction_length_q <= pwdata[ReduceW-1:0];
				REG_CHANNELS:  channel_count_q    <= pwdata[ChannelW-1:0];
				REG_ORDER:     nibble_order_q     <= pwdata[0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_REDUCTION: prdata = {20'd0, reduction_length_q};
			REG_CHANNELS:  prdata = {23'd0, channel_count_q};
			REG_ORDER:     prdata = {31'd0, nibble_order_q};
			default:       prdata = 32'd0;
		endcase
	end

	// Input register
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			item_s1 <= weight;
		end
	end

	// Geometry and skip checks
	logic [9:0] groups_sum;
	logic [6:0] groups;
	logic       geom_ok;
	logic       skip;

	assign groups_sum = {1'b0, channel_count_q} + 10'd7;
	assign groups     = groups_sum[9:3];
	assign geom_ok    = (reduction_length_q >= 12'd32)
		&& (reduction_length_q <= ReduceW'(MaxReduction))
		&& (reduction_length_q[4:0] == 5'd0)
		&& (groups >= 7'd2) && (groups <= 7'(MaxGroups));
	assign skip = (item_s1.channel >= channel_count_q)
		|| (item_s1.reduce_index >= reduction_length_q)
		|| (item_s1.reduce_index[4] != item_s1.channel[0]);

	// Block and slot of the channel group
	logic [6:0] grp;
	logic [4:0] b3;
	logic [6:0] two_b3;
	logic [6:0] rel;
	logic [6:0] rest;
	logic [5:0] blk;
	logic [1:0] slot;
	logic [5:0] half_groups;

	assign grp         = {1'b0, item_s1.channel[8:3]};
	assign b3          = 5'((groups - 7'd1) >> 2);
	assign two_b3      = {1'b0, b3, 1'b0};
	assign rel         = grp - two_b3;
	assign rest        = grp - two_b3 - 7'd3;
	assign half_groups = groups[6:1];

	always_comb begin
		if (!groups[0]) begin
			blk  = grp[6:1];
			slot = (blk == half_groups - 6'd1) ? {1'b0, grp[0]} : {grp[0], 1'b0};
		end else if (grp < two_b3) begin
			blk  = grp[6:1];
			slot = {grp[0], 1'b0};
		end else if (grp < two_b3 + 7'd3) begin
			blk  = {1'b0, b3};
			slot = (groups[1:0] == 2'd3) ? slot_mod3(rel[1:0]) : slot_mod1(rel[1:0]);
		end else begin
			blk  = 6'({1'b0, b3} + 6'd1 + rest[6:1]);
			slot = rest[0] ? 2'd3 : 2'd1;
		end
	end

	// Byte address and nibble half
	logic [17:0] blk_prod;
	logic [21:0] addr_sum;
	logic [2:0]  byte_off;
	logic        high;
	logic [3:0]  j;

	assign j        = item_s1.reduce_index[3:0];
	assign blk_prod = 18'(blk) * 18'(reduction_length_q);

	always_comb begin
		if (nibble_order_q == ORDER_SPLIT) begin
			byte_off = j[2:0];
			high     = j[3];
		end else begin
			byte_off = j[3:1];
			high     = j[0];
		end
	end

	assign addr_sum = {1'b0, blk_prod, 3'd0}
		+ {14'd0, slot, 6'd0}
		+ {16'd0, item_s1.channel[2:0], 3'd0}
		+ {7'd0, item_s1.reduce_index[11:5], 8'd0}
		+ {19'd0, byte_off};

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			if (!geom_ok) begin
				place_s2 <= '{status: STATUS_GEOMETRY, byte_address: '0,
					high_half: 1'b0, nibble: '0};
			end else if (skip) begin
				place_s2 <= '{status: STATUS_SKIPPED, byte_address: '0,
					high_half: 1'b0, nibble: '0};
			end else begin
				place_s2 <= '{status: STATUS_PLACED, byte_address: addr_sum[AddrW-1:0],
					high_half: high, nibble: item_s1.weight_byte[NibbleW-1:0]};
			end
		end
	end

	assign done  = valid_s2;
	assign place = place_s2;

endmodule

// ----- sim/int4_weight_nibble_placer_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for int4_weight_nibble_placer: directed table, then random phases.
// Uses its own placement predictor and APB register writes; depends on i4wnp_pkg and the block.
module int4_weight_nibble_placer_tb;
	import i4wnp_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 2000;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam logic [1:0]  REG_SPARE    = 2'd3;	// no register at this index

	typedef enum logic {ROW_WEIGHT, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t    kind;
		logic [1:0]   reg_idx;
		logic [31:0]  value;
		weight_item_t item;
		logic         typed;
		place_item_t  result;
	} plan_row_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         start;
	logic         busy;
	weight_item_t weight;
	logic         done;
	place_item_t  place;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [3:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	// Shadow copy of the configuration registers
	logic [ReduceW-1:0]  cfg_reduction;
	logic [ChannelW-1:0] cfg_channels;
	logic                cfg_order;

	place_item_t placements_due[$];
	plan_row_t   directed_plan[$];
	int unsigned mismatches = 0;
	int unsigned weights_sent = 0;
	int unsigned cycles = 0;

	int4_weight_nibble_placer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.weight  (weight),
		.done    (done),
		.place   (place),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("int4_weight_nibble_placer test failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h, expected %0h (cycle %0d)", what, got, want, cycles);
		mismatches++;
	endtask

	// Expected placement of one weight under the current shadow configuration
	function automatic place_item_t predict_placement(input weight_item_t w);
		place_item_t r;
		int unsigned n, k, kk, nn, groups, g, blk, slot, b3, idx, rr, j, addr;
		r = '0;
		n = w.channel;
		k = w.reduce_index;
		kk = cfg_reduction;
		nn = cfg_channels;
		groups = (nn + 7) / 8;
		r.status = STATUS_PLACED;
		if (kk < 32 || kk > MaxReduction || kk % 32 != 0 || groups < 2 || groups > MaxGroups) begin
			r.status = STATUS_GEOMETRY;
			return r;
		end
		if (n >= nn || k >= kk || ((k >> 4) & 1) != (n & 1)) begin
			r.status = STATUS_SKIPPED;
			return r;
		end
		g = n / 8;
		if (groups % 2 == 0) begin
			// even count: slots 0 and 2, last block packs into 0 and 1
			blk = g / 2;
			slot = (blk == groups / 2 - 1) ? g % 2 : (g % 2) * 2;
		end else begin
			// odd count: a three-slot block sits after the leading pairs
			b3 = (groups - 1) / 4;
			if (g < 2 * b3) begin
				blk = g / 2;
				slot = (g % 2) * 2;
			end else if (g < 2 * b3 + 3) begin
				idx = (g - 2 * b3) % 3;
				blk = b3;
				if (idx == 0)
					slot = 0;
				else if (idx == 1)
					slot = (groups % 4 == 3) ? 2 : 1;
				else
					slot = 3;
			end else begin
				rr = g - (2 * b3 + 3);
				blk = b3 + 1 + rr / 2;
				slot = (rr % 2) ? 3 : 1;
			end
		end
		j = k % 16;
		addr = blk * 8 * kk + slot * 64 + (n % 8) * 8 + (k >> 5) * 256;
		if (cfg_order == ORDER_SPLIT) begin
			addr += j % 8;
			r.high_half = (j >= 8);
		end else begin
			addr += j / 2;
			r.high_half = j[0];
		end
		r.byte_address = addr[AddrW-1:0];
		r.nibble = w.weight_byte[3:0];
		return r;
	endfunction

	// Sender gap: mostly none, some short, a few long
	function automatic int unsigned idle_cycles(input bit burst);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (burst || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one weight, wait for acceptance, log what should come back, then idle
	task automatic send_weight(input weight_item_t w, input logic typed,
			input place_item_t result, input bit burst);
		int unsigned gap;
		weight <= w;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		placements_due.push_back(typed ? result : predict_placement(w));
		weights_sent++;
		gap = idle_cycles(burst);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Register write once the block has drained, with readback of real registers
	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] want;
		start <= 1'b0;
		while (placements_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_REDUCTION: cfg_reduction = value[ReduceW-1:0];
			REG_CHANNELS:  cfg_channels = value[ChannelW-1:0];
			REG_ORDER:     cfg_order = value[0];
			default:       ;
		endcase
		want = '0;
		case (idx)
			REG_REDUCTION: want[ReduceW-1:0] = cfg_reduction;
			REG_CHANNELS:  want[ChannelW-1:0] = cfg_channels;
			REG_ORDER:     want[0] = cfg_order;
			default:       ;
		endcase
		if (idx == REG_SPARE) begin
			psel <= 1'b0;
			penable <= 1'b0;
			return;
		end
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			report_mismatch("register readback", prdata, want);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic void plan_write(input logic [1:0] idx, input logic [31:0] value);
		plan_row_t r;
		r = '{kind: ROW_WRITE, default: '0};
		r.reg_idx = idx;
		r.value = value;
		directed_plan.push_back(r);
	endfunction

	function automatic void plan_weight(input int unsigned n, input int unsigned k,
			input int unsigned wb, input int unsigned typed, input status_t st,
			input int unsigned addr, input int unsigned high, input int unsigned nib);
		plan_row_t r;
		r = '{kind: ROW_WEIGHT, default: '0};
		r.item.channel = ChannelW'(n);
		r.item.reduce_index = ReduceW'(k);
		r.item.weight_byte = ByteW'(wb);
		r.typed = (typed != 0);
		r.result.status = st;
		r.result.byte_address = AddrW'(addr);
		r.result.high_half = (high != 0);
		r.result.nibble = NibbleW'(nib);
		directed_plan.push_back(r);
	endfunction

	// Random weight: mostly in range and fed to its channel, the rest anything
	function automatic weight_item_t random_weight();
		weight_item_t w;
		w.channel = ChannelW'($urandom_range(0, 511));
		w.reduce_index = ReduceW'($urandom_range(0, 4095));
		w.weight_byte = ByteW'($urandom_range(0, 255));
		if (cfg_channels != 0 && cfg_reduction >= 32 && $urandom_range(0, 9) < 8) begin
			w.channel = ChannelW'($urandom_range(0, cfg_channels - 1));
			w.reduce_index = ReduceW'($urandom_range(0, cfg_reduction - 1));
			w.reduce_index[4] = w.channel[0];
		end
		return w;
	endfunction

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		place_item_t want;
		if (arst_n && done) begin
			if (placements_due.size() == 0) begin
				report_mismatch("result with none expected", 32'(place), '0);
			end else begin
				want = placements_due.pop_front();
				if (place.status !== want.status)
					report_mismatch("status", 32'(place.status), 32'(want.status));
				if (place.byte_address !== want.byte_address)
					report_mismatch("byte_address", 32'(place.byte_address),
						32'(want.byte_address));
				if (place.high_half !== want.high_half)
					report_mismatch("high_half", 32'(place.high_half), 32'(want.high_half));
				if (place.nibble !== want.nibble)
					report_mismatch("nibble", 32'(place.nibble), 32'(want.nibble));
			end
		end
	end

	initial begin
		logic [31:0] reg_value;
		int unsigned phase_len;
		bit burst;
		arst_n <= 1'b0;
		start <= 1'b0;
		weight <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cfg_reduction = ReductionReset;
		cfg_channels = ChannelReset;
		cfg_order = OrderReset;

		// Reset geometry: K=64, N=64, four blocks, last block in slots 0 and 1
		plan_weight(0, 0, 8'hff, 1, STATUS_PLACED, 0, 0, 4'hf);
		plan_weight(0, 15, 8'h0a, 1, STATUS_PLACED, 7, 1, 4'ha);
		plan_weight(63, 63, 8'h3c, 1, STATUS_PLACED, 1919, 1, 4'hc);
		plan_weight(1, 0, 8'h5f, 1, STATUS_SKIPPED, 0, 0, 0);	// half not fed
		plan_weight(64, 0, 8'hff, 1, STATUS_SKIPPED, 0, 0, 0);	// channel out of range
		plan_weight(0, 64, 8'hff, 1, STATUS_SKIPPED, 0, 0, 0);	// k out of range
		plan_weight(511, 4095, 8'hff, 1, STATUS_SKIPPED, 0, 0, 0);
		plan_weight(1, 16, 8'h00, 0, STATUS_PLACED, 0, 0, 0);
		plan_weight(62, 47, 8'ha5, 0, STATUS_PLACED, 0, 0, 0);
		// Split nibble order
		plan_write(REG_ORDER, {31'd0, ORDER_SPLIT});
		plan_weight(0, 15, 8'h07, 1, STATUS_PLACED, 7, 1, 4'h7);
		plan_weight(0, 8, 8'h09, 1, STATUS_PLACED, 0, 1, 4'h9);
		plan_weight(0, 7, 8'hf0, 1, STATUS_PLACED, 7, 0, 4'h0);
		// Write to an index with no register changes nothing
		plan_write(REG_SPARE, 32'hffff_ffff);
		plan_weight(3, 31, 8'h6b, 0, STATUS_PLACED, 0, 0, 0);
		// Unsupported geometry wins over range checks
		plan_write(REG_REDUCTION, 32'd0);
		plan_weight(0, 0, 8'hff, 1, STATUS_GEOMETRY, 0, 0, 0);
		plan_weight(511, 4095, 8'hff, 1, STATUS_GEOMETRY, 0, 0, 0);
		plan_write(REG_REDUCTION, 32'd4095);
		plan_weight(0, 0, 8'hff, 1, STATUS_GEOMETRY, 0, 0, 0);
		plan_write(REG_REDUCTION, 32'd2080);
		plan_weight(0, 0, 8'hff, 1, STATUS_GEOMETRY, 0, 0, 0);
		plan_write(REG_REDUCTION, 32'd33);
		plan_weight(0, 0, 8'hff, 1, STATUS_GEOMETRY, 0, 0, 0);
		plan_write(REG_REDUCTION, 32'd2048);
		plan_write(REG_CHANNELS, 32'd0);
		plan_weight(0, 0, 8'hff, 1, STATUS_GEOMETRY, 0, 0, 0);
		plan_write(REG_CHANNELS, 32'd511);
		plan_weight(0, 0, 8'hff, 1, STATUS_GEOMETRY, 0, 0, 0);
		plan_write(REG_CHANNELS, 32'd8);
		plan_weight(0, 0, 8'hff, 1, STATUS_GEOMETRY, 0, 0, 0);
		// Smallest and largest supported geometries, then odd group counts
		plan_write(REG_CHANNELS, 32'd9);
		plan_write(REG_REDUCTION, 32'd32);
		plan_weight(9, 31, 8'h96, 0, STATUS_PLACED, 0, 0, 0);
		plan_weight(8, 15, 8'h69, 0, STATUS_PLACED, 0, 0, 0);
		plan_write(REG_CHANNELS, 32'd256);
		plan_write(REG_REDUCTION, 32'd2048);
		plan_weight(255, 2047, 8'hff, 0, STATUS_PLACED, 0, 0, 0);
		plan_write(REG_CHANNELS, 32'd17);
		plan_weight(16, 0, 8'h3e, 0, STATUS_PLACED, 0, 0, 0);
		plan_write(REG_CHANNELS, 32'd33);
		plan_weight(33, 16, 8'hc1, 0, STATUS_PLACED, 0, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == ROW_WRITE)
				write_register(directed_plan[i].reg_idx, directed_plan[i].value);
			else
				send_weight(directed_plan[i].item, directed_plan[i].typed,
					directed_plan[i].result, 1'b0);
		end

		// Random phases, each under a fresh configuration
		weights_sent = 0;
		while (weights_sent < RANDOM_ITEMS) begin
			reg_value = $urandom & ~32'hfff;
			case ($urandom_range(0, 9))
				0:       reg_value[11:0] = 12'd32;
				1:       reg_value[11:0] = 12'd2048;
				2:       reg_value[11:0] = 12'($urandom_range(0, 4095));
				3:       reg_value[11:0] = 12'(32 * $urandom_range(1, 64));
				default: reg_value[11:0] = 12'(32 * $urandom_range(1, 16));
			endcase
			write_register(REG_REDUCTION, reg_value);
			reg_value = $urandom & ~32'h1ff;
			case ($urandom_range(0, 9))
				0:       reg_value[8:0] = 9'd9;
				1:       reg_value[8:0] = 9'd256;
				2:       reg_value[8:0] = 9'($urandom_range(0, 511));
				default: reg_value[8:0] = 9'($urandom_range(9, 256));
			endcase
			write_register(REG_CHANNELS, reg_value);
			write_register(REG_ORDER, $urandom);
			if ($urandom_range(0, 4) == 0)
				write_register(REG_SPARE, $urandom);
			burst = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(50, 150);
			repeat (phase_len)
				send_weight(random_weight(), 1'b0, '0, burst);
		end

		start <= 1'b0;
		while (placements_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("int4_weight_nibble_placer test passed");
		else
			$display("int4_weight_nibble_placer test failed");
		$finish;
	end

endmodule
